>>> hw/rtl/lps_pkg.sv
// Shared types and constants for the longest palindromic subsequence engine.
// Used by the cell chain and the top level; depends on nothing.
package lps_pkg;

    typedef enum logic [1:0] {
        CH_SINGLE = 2'd0,
        CH_MATCH  = 2'd1,
        CH_DROPR  = 2'd2,
        CH_DROPL  = 2'd3
    } t_choice;

    typedef struct packed {
        logic ld_en;
        logic en;
        logic start;
    } t_cell_ctl;

endpackage

>>> hw/rtl/lps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the symbol store, the choice table and the trace buffer.
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/lps_cell.sv
// One column cell of the interval-table chain: holds its symbol and the current
// and previous row lengths of its column. Depends on lps_pkg.
module lps_cell import lps_pkg::*; #(
    parameter int LW = 7
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [7:0]    i_ld_sym,
    input  logic [7:0]    i_sym_row,
    input  logic [LW-1:0] i_left_cur,
    input  logic [LW-1:0] i_left_old,
    output logic [LW-1:0] o_cur,
    output logic [LW-1:0] o_old,
    output logic [LW-1:0] o_res,
    output logic [1:0]    o_ch
);
    logic [7:0]    r_sym;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] r_old;
    logic [LW-1:0] w_res;
    t_choice       w_ch;

    always_comb begin
        if (i_ctl.start) begin
            w_res = LW'(1);
            w_ch  = CH_SINGLE;
        end else if (i_sym_row == r_sym) begin
            w_res = i_left_old + LW'(2);
            w_ch  = CH_MATCH;
        end else if (i_left_cur > r_cur) begin
            w_res = i_left_cur;
            w_ch  = CH_DROPR;
        end else begin
            w_res = r_cur;
            w_ch  = CH_DROPL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_en) begin
            r_sym <= i_ld_sym;
        end
        if (i_ctl.en) begin
            r_cur <= w_res;
            r_old <= i_ctl.start ? '0 : r_cur;
        end
    end

    assign o_cur = r_cur;
    assign o_old = r_old;
    assign o_res = i_ctl.en ? w_res : '0;
    assign o_ch  = i_ctl.en ? w_ch : 2'b00;
endmodule

>>> hw/rtl/longest_palindromic_subsequence_top.sv
// Longest palindromic subsequence engine: symbols stream in one transfer per
// cycle while in S_LOAD; after the transfer with tlast the table fill runs
// row by row for n stored symbols (one column cell updates per cycle along
// the chain), a traceback step passes S_TR_RD and S_TR_EX for the registered
// choice RAM read, a result transfer S_EM_RD, S_EM_LD, S_EM_WAIT for trace RAM.
// Depends on lps_pkg, lps_ram and lps_cell.
module longest_palindromic_subsequence_top import lps_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // symbol
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // out_symbol, pal_length, overflow
    output logic        o_m_axis_tlast
);
    localparam int IW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int CD  = MAX_LEN * MAX_LEN;
    localparam int CAW = $clog2(CD);
    localparam int LD  = MAX_LEN / 2;
    localparam int LBW = (LD > 1) ? $clog2(LD) : 1;

    typedef enum logic [2:0] {
        S_LOAD, S_ROW, S_TR_RD, S_TR_EX, S_EM_RD, S_EM_LD, S_EM_WAIT
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [CW-1:0] r_n;
    logic [IW-1:0] r_row;
    logic [IW-1:0] r_col;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_ti;
    logic [CW-1:0] r_tj;
    logic [CW-1:0] r_nl;
    logic          r_has_mid;
    logic [7:0]    r_mid;
    logic [CW-1:0] r_k;
    logic [7:0]    r_osym;
    logic          r_olast;

    logic          w_in_acc;
    logic          w_out_acc;
    logic [CW-1:0] w_cnt_next;
    logic [IW-1:0] w_last_col;
    logic [CW-1:0] w_pos;
    logic [7:0]    w_sym_rd;
    logic [1:0]    w_ch_rd;
    logic [7:0]    w_lb_rd;
    logic [IW-1:0] w_sym_raddr;
    logic [CW-1:0] w_lb_idx;

    logic [CW-1:0] w_cur [MAX_LEN];
    logic [CW-1:0] w_old [MAX_LEN];
    logic [CW-1:0] w_res [MAX_LEN];
    logic [1:0]    w_chs [MAX_LEN];
    logic [CW-1:0] w_res_bus;
    logic [1:0]    w_ch_bus;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign w_cnt_next = (r_cnt < CW'(MAX_LEN)) ? r_cnt + CW'(1) : r_cnt;
    assign w_last_col = IW'(r_n - CW'(1));
    assign w_pos      = CW'({r_nl, 1'b0}) + CW'(r_has_mid);

    genvar g;
    generate
        for (g = 0; g < MAX_LEN; g++) begin : g_cell
            t_cell_ctl     w_ctl;
            logic [CW-1:0] w_lc;
            logic [CW-1:0] w_lo;
            assign w_ctl.ld_en = w_in_acc && (r_cnt == CW'(g));
            assign w_ctl.en    = (r_state == S_ROW) && (r_col == IW'(g));
            assign w_ctl.start = (r_col == r_row);
            if (g == 0) begin : g_first
                assign w_lc = '0;
                assign w_lo = '0;
            end else begin : g_rest
                assign w_lc = w_cur[g-1];
                assign w_lo = w_old[g-1];
            end
            lps_cell #(.LW(CW)) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_ld_sym   (i_s_axis_tdata),
                .i_sym_row  (w_sym_rd),
                .i_left_cur (w_lc),
                .i_left_old (w_lo),
                .o_cur      (w_cur[g]),
                .o_old      (w_old[g]),
                .o_res      (w_res[g]),
                .o_ch       (w_chs[g])
            );
        end
    endgenerate

    always_comb begin
        w_res_bus = '0;
        w_ch_bus  = 2'b00;
        for (int k = 0; k < MAX_LEN; k++) begin
            w_res_bus = w_res_bus | w_res[k];
            w_ch_bus  = w_ch_bus | w_chs[k];
        end
    end

    assign w_sym_raddr = (r_state == S_ROW) ? r_row : r_ti[IW-1:0];

    lps_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (r_cnt < CW'(MAX_LEN))),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (w_sym_raddr),
        .o_rdata (w_sym_rd)
    );

    lps_ram #(.WIDTH(2), .DEPTH(CD)) u_choice_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ROW),
        .i_waddr (CAW'(r_row) * CAW'(MAX_LEN) + CAW'(r_col)),
        .i_wdata (w_ch_bus),
        .i_raddr (CAW'(r_ti[IW-1:0]) * CAW'(MAX_LEN) + CAW'(r_tj[IW-1:0])),
        .o_rdata (w_ch_rd)
    );

    assign w_lb_idx = (r_k < r_nl) ? r_k : (w_pos - CW'(1) - r_k);

    lps_ram #(.WIDTH(8), .DEPTH(LD)) u_trace_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_TR_EX) && (w_ch_rd == CH_MATCH)),
        .i_waddr (r_nl[LBW-1:0]),
        .i_wdata (w_sym_rd),
        .i_raddr (w_lb_idx[LBW-1:0]),
        .o_rdata (w_lb_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        r_cnt <= w_cnt_next;
                        if (r_cnt == CW'(MAX_LEN)) begin
                            r_drop <= 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_n     <= w_cnt_next;
                            r_row   <= IW'(w_cnt_next - CW'(1));
                            r_col   <= IW'(w_cnt_next - CW'(1));
                            r_state <= S_ROW;
                        end
                    end
                end
                S_ROW: begin
                    if (r_col == w_last_col) begin
                        if (r_row == '0) begin
                            r_total   <= w_res_bus;
                            r_ti      <= '0;
                            r_tj      <= r_n - CW'(1);
                            r_nl      <= '0;
                            r_has_mid <= 1'b0;
                            r_state   <= S_TR_RD;
                        end else begin
                            r_row <= r_row - IW'(1);
                            r_col <= r_row - IW'(1);
                        end
                    end else begin
                        r_col <= r_col + IW'(1);
                    end
                end
                S_TR_RD: begin
                    r_state <= S_TR_EX;
                end
                S_TR_EX: begin
                    r_state <= S_EM_RD;
                    r_k     <= '0;
                    case (w_ch_rd)
                        CH_SINGLE: begin
                            r_has_mid <= 1'b1;
                            r_mid     <= w_sym_rd;
                        end
                        CH_MATCH: begin
                            r_nl <= r_nl + CW'(1);
                            if (r_tj != '0) begin
                                r_ti <= r_ti + CW'(1);
                                r_tj <= r_tj - CW'(1);
                                if (r_ti + CW'(2) <= r_tj) begin
                                    r_state <= S_TR_RD;
                                end
                            end
                        end
                        CH_DROPR: begin
                            if (r_tj != '0) begin
                                r_tj <= r_tj - CW'(1);
                                if (r_ti + CW'(1) <= r_tj) begin
                                    r_state <= S_TR_RD;
                                end
                            end
                        end
                        default: begin
                            r_ti <= r_ti + CW'(1);
                            if (r_ti + CW'(1) <= r_tj) begin
                                r_state <= S_TR_RD;
                            end
                        end
                    endcase
                end
                S_EM_RD: begin
                    r_state <= S_EM_LD;
                end
                S_EM_LD: begin
                    r_osym  <= (r_has_mid && (r_k == r_nl)) ? r_mid : w_lb_rd;
                    r_olast <= (r_k == w_pos - CW'(1));
                    r_state <= S_EM_WAIT;
                end
                S_EM_WAIT: begin
                    if (w_out_acc) begin
                        if (r_olast) begin
                            r_cnt   <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign o_m_axis_tvalid = (r_state == S_EM_WAIT);
    assign o_m_axis_tdata  = {r_drop, 7'(r_total), r_osym};
    assign o_m_axis_tlast  = r_olast;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input and output sides active together");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LEN))
        else $error("symbol count above capacity");
    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_col >= r_row) && (r_col <= w_last_col))
        else $error("fill column outside the current row");
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && r_olast) |=> (r_cnt == '0) && !r_drop)
        else $error("string state not cleared after the final transfer");
endmodule
